[rtl/edpq_pkg.sv]
`timescale 1ns / 1ps

package edpq_pkg;

    // Phase queue geometry.
    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH) + 1;

    // Field widths.
    localparam int CNT_W    = 16;
    localparam int GLIM_W   = 8;
    localparam int DC_W     = 5;
    localparam int STEP_W   = 10;
    localparam int QUO_W    = 9;
    localparam int QFILL_W  = 9;
    localparam int PHASE_W  = 2;
    localparam int PIDX_W   = 3;
    localparam int DCNT_W   = $clog2(QUO_W);

    // Configuration register map.
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_GLITCH_LIMIT  = 1'b0;
    localparam logic REG_DETENT_COUNTS = 1'b1;

    localparam logic [GLIM_W-1:0] GLITCH_LIMIT_RST  = 8'd20;
    localparam logic [DC_W-1:0]   DETENT_COUNTS_RST = 5'd4;
    localparam logic [DC_W-1:0]   DETENT_MIN        = 5'd1;
    localparam logic [DC_W-1:0]   DETENT_MAX        = 5'd16;

    // Five phases are queued for each detent step.
    localparam logic [PIDX_W-1:0] PIDX_LAST = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic latch;
        logic sample;
        logic div_step;
        logic div_commit;
        logic push;
        logic pop;
        logic load_out;
    } edpq_cmd_t;

    typedef struct packed {
        logic in_pop;
        logic reject;
        logic div_last;
        logic quo_zero;
        logic push_last;
        logic out_free;
    } edpq_sts_t;

    // Quadrature phase AB for one position of a detent step.
    function automatic logic [PHASE_W-1:0] phase_of(input logic ccw,
                                                    input logic [PIDX_W-1:0] idx);
        logic [PHASE_W-1:0] ph;
        case (idx)
            3'd1:    ph = ccw ? 2'd2 : 2'd1;
            3'd2:    ph = 2'd3;
            3'd3:    ph = ccw ? 2'd1 : 2'd2;
            default: ph = 2'd0;
        endcase
        return ph;
    endfunction

endpackage

[rtl/encoder_detent_phase_queue_top.sv]
// Sequence: a pop passes through the POP and FINISH states, and a rejected sample through
// SAMPLE and FINISH; an accepted sample runs SAMPLE, the serial divider (DIV, DIVEND) and,
// for a nonzero quotient, PUSH, which writes each phase to the single-port phase memory.
// Throughput: one transaction at a time; the next is taken once the result sits in the
// output register, which may still be waiting on out_stall.
// Reset: rst_n clears the queue pointers, fill count, counter history and remainder.
`timescale 1ns / 1ps

module encoder_detent_phase_queue_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [edpq_pkg::CNT_W-1:0]         counter_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [edpq_pkg::STEP_W-1:0] step_count,
    output logic                               rejected,
    output logic                               dropped,
    output logic [edpq_pkg::PHASE_W-1:0]       phase,
    output logic                               phase_valid,
    output logic [edpq_pkg::QFILL_W-1:0]       queue_fill,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [edpq_pkg::APB_AW-1:0]        paddr,
    input  logic [edpq_pkg::APB_DW-1:0]        pwdata,
    output logic [edpq_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import edpq_pkg::*;

    edpq_cmd_t         cmd;
    edpq_sts_t         sts;
    logic [GLIM_W-1:0] glitch_limit;
    logic [DC_W-1:0]   detent_counts;

    edpq_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .glitch_limit  (glitch_limit),
        .detent_counts (detent_counts)
    );

    edpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    edpq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .glitch_limit  (glitch_limit),
        .detent_counts (detent_counts),
        .command       (command),
        .counter_value (counter_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .step_count    (step_count),
        .rejected      (rejected),
        .dropped       (dropped),
        .phase         (phase),
        .phase_valid   (phase_valid),
        .queue_fill    (queue_fill)
    );

    // Once a transaction is taken the block is busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again straight after a transaction");

    // A rejected sample never yields steps or queues phases.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (step_count == '0 && !dropped && !phase_valid))
        else $error("rejected sample carries steps or phases");

    // A pop result carries no sample information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase_valid) |-> (step_count == '0 && !rejected && !dropped))
        else $error("pop result mixed with sample fields");

    // Output is only raised by the controller, never while the input side is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in progress");

endmodule

[rtl/edpq_regs.sv]
`timescale 1ns / 1ps

module edpq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [edpq_pkg::APB_AW-1:0]   paddr,
    input  logic [edpq_pkg::APB_DW-1:0]   pwdata,
    output logic [edpq_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [edpq_pkg::GLIM_W-1:0]   glitch_limit,
    output logic [edpq_pkg::DC_W-1:0]     detent_counts
);
    import edpq_pkg::*;

    logic [GLIM_W-1:0] glitch_limit_reg;
    logic [DC_W-1:0]   detent_counts_reg;
    logic              wr_en;

    // Registers sit on a 4-byte pitch, so bit 2 picks the register.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_limit_reg  <= GLITCH_LIMIT_RST;
            detent_counts_reg <= DETENT_COUNTS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_GLITCH_LIMIT:  glitch_limit_reg  <= pwdata[GLIM_W-1:0];
                REG_DETENT_COUNTS: detent_counts_reg <= pwdata[DC_W-1:0];
                default:           glitch_limit_reg  <= glitch_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GLITCH_LIMIT:  prdata = APB_DW'(glitch_limit_reg);
            REG_DETENT_COUNTS: prdata = APB_DW'(detent_counts_reg);
            default:           prdata = '0;
        endcase
    end

    assign glitch_limit  = glitch_limit_reg;
    assign detent_counts = detent_counts_reg;

endmodule

[rtl/edpq_ctrl.sv]
`timescale 1ns / 1ps

module edpq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  edpq_pkg::edpq_sts_t   sts,
    output edpq_pkg::edpq_cmd_t   cmd
);
    import edpq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SAMPLE = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_DIVEND = 7'b0001000,
        ST_PUSH   = 7'b0010000,
        ST_POP    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = sts.in_pop ? ST_POP : ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                cmd.sample = 1'b1;
                state_next = sts.reject ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DIVEND;
            end
            ST_DIVEND:
            begin
                cmd.div_commit = 1'b1;
                state_next     = sts.quo_zero ? ST_FINISH : ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.push_last)
                    state_next = ST_FINISH;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait here until the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[rtl/edpq_dp.sv]
`timescale 1ns / 1ps

module edpq_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  edpq_pkg::edpq_cmd_t             cmd,
    output edpq_pkg::edpq_sts_t             sts,
    input  logic [edpq_pkg::GLIM_W-1:0]     glitch_limit,
    input  logic [edpq_pkg::DC_W-1:0]       detent_counts,
    input  logic                            command,
    input  logic [edpq_pkg::CNT_W-1:0]      counter_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [edpq_pkg::STEP_W-1:0] step_count,
    output logic                            rejected,
    output logic                            dropped,
    output logic [edpq_pkg::PHASE_W-1:0]    phase,
    output logic                            phase_valid,
    output logic [edpq_pkg::QFILL_W-1:0]    queue_fill
);
    import edpq_pkg::*;

    // Item capture and sample state.
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  prev_reg;
    logic [DC_W-1:0]   rem_acc_reg;
    logic              rej_reg;
    logic              drop_reg;
    logic              pv_reg;
    logic              neg_reg;

    // Restoring divider.
    logic [QUO_W-1:0]  quo_reg;
    logic [DC_W-1:0]   div_rem_reg;
    logic [DC_W-1:0]   dvs_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    // Phase push sequencer.
    logic [QUO_W-1:0]  step_left_reg;
    logic [PIDX_W-1:0] pidx_reg;

    // Phase queue.
    logic [PHASE_W-1:0] mem [QUEUE_DEPTH];
    logic [PHASE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               full;
    logic               empty;

    // Output register.
    logic                     out_valid_reg;
    logic signed [STEP_W-1:0] out_step_reg;
    logic                     out_rej_reg;
    logic                     out_drop_reg;
    logic [PHASE_W-1:0]       out_phase_reg;
    logic                     out_pv_reg;
    logic [QFILL_W-1:0]       out_fill_reg;

    logic [CNT_W-1:0]   diff;
    logic [CNT_W-1:0]   mag;
    logic               reject;
    logic [STEP_W-1:0]  sum;
    logic [STEP_W-1:0]  sum_mag;
    logic [DC_W-1:0]    dc_eff;
    logic [DC_W:0]      trial;
    logic               trial_ge;
    logic [DC_W-1:0]    rem_step;
    logic [PHASE_W-1:0] push_phase;

    // Wrapped difference; a change of half the counter range counts as negative.
    assign diff   = cnt_reg - prev_reg;
    assign mag    = diff[CNT_W-1] ? (CNT_W'(0) - diff) : diff;
    assign reject = mag > CNT_W'(glitch_limit);

    // An accepted difference is within the glitch limit, so ten bits hold the sum.
    assign sum     = {{(STEP_W-DC_W){rem_acc_reg[DC_W-1]}}, rem_acc_reg} + diff[STEP_W-1:0];
    assign sum_mag = sum[STEP_W-1] ? (STEP_W'(0) - sum) : sum;

    always_comb
    begin
        if (detent_counts < DETENT_MIN)
            dc_eff = DETENT_MIN;
        else if (detent_counts > DETENT_MAX)
            dc_eff = DETENT_MAX;
        else
            dc_eff = detent_counts;
    end

    assign trial    = {div_rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};
    assign rem_step = trial_ge ? DC_W'(trial - {1'b0, dvs_reg}) : trial[DC_W-1:0];

    assign push_phase = phase_of(neg_reg, pidx_reg);

    assign full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            rem_acc_reg <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (cmd.sample)
            begin
                prev_reg <= cnt_reg;
            end
            if (cmd.div_commit)
            begin
                // The remainder keeps the sign of the dividend.
                rem_acc_reg <= neg_reg ? (DC_W'(0) - div_rem_reg) : div_rem_reg;
            end
            if (cmd.push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
                fill_reg   <= fill_reg + 1'b1;
            end
            if (cmd.pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
                fill_reg   <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cnt_reg  <= counter_value;
            rej_reg  <= 1'b0;
            drop_reg <= 1'b0;
            pv_reg   <= 1'b0;
            quo_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        if (cmd.sample)
        begin
            rej_reg     <= reject;
            neg_reg     <= sum[STEP_W-1];
            quo_reg     <= reject ? '0 : sum_mag[QUO_W-1:0];
            div_rem_reg <= '0;
            dvs_reg     <= dc_eff;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[QUO_W-2:0], trial_ge};
            div_rem_reg <= rem_step;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.div_commit)
        begin
            step_left_reg <= quo_reg;
            pidx_reg      <= '0;
        end
        if (cmd.push)
        begin
            if (full)
                drop_reg <= 1'b1;
            if (pidx_reg == PIDX_LAST)
            begin
                pidx_reg      <= '0;
                step_left_reg <= step_left_reg - 1'b1;
            end
            else
            begin
                pidx_reg <= pidx_reg + 1'b1;
            end
        end
        if (cmd.pop)
        begin
            pv_reg      <= !empty;
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
            mem[wr_ptr_reg] <= push_phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_step_reg  <= neg_reg ? (STEP_W'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};
            out_rej_reg   <= rej_reg;
            out_drop_reg  <= drop_reg;
            out_phase_reg <= pv_reg ? rd_data_reg : '0;
            out_pv_reg    <= pv_reg;
            out_fill_reg  <= QFILL_W'(fill_reg);
        end
    end

    assign sts.in_pop    = (command == CMD_POP);
    assign sts.reject    = reject;
    assign sts.div_last  = (div_cnt_reg == DCNT_W'(QUO_W - 1));
    assign sts.quo_zero  = (quo_reg == '0);
    assign sts.push_last = (step_left_reg == QUO_W'(1)) && (pidx_reg == PIDX_LAST);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign step_count  = out_step_reg;
    assign rejected    = out_rej_reg;
    assign dropped     = out_drop_reg;
    assign phase       = out_phase_reg;
    assign phase_valid = out_pv_reg;
    assign queue_fill  = out_fill_reg;

endmodule
